/* rtl/core/u2da_pkg.sv */
// shared constants and control types for the decimal ascii converter
package u2da_pkg;

    localparam int VALUE_W        = 64;
    localparam int VALUE_BITS_DEF = 64;
    localparam int DIGIT_SLOTS    = 20;
    localparam int DIGIT_W        = 4;
    localparam int IDX_W          = 5;
    localparam int CHAR_W         = 6;

    localparam logic [CHAR_W-1:0]  CH_ZERO   = 6'd48;
    localparam logic [CHAR_W-1:0]  CH_NUL    = 6'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic out_digit;
        logic out_term;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic idx_zero;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/u2da_ctrl.sv */
// control state machine: load, shift-add-3 steps, digit emission, terminator
module u2da_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  u2da_pkg::t_sts i_sts,
    output u2da_pkg::t_cmd o_cmd
);
    import u2da_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_started, n_started;
    t_cmd       cmd;

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    cmd.load  = 1'b1;
                    n_started = 1'b0;
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.shift = 1'b1;
                    // leading zero suppression
                    if (r_started || !i_sts.top_zero || i_sts.idx_zero) begin
                        cmd.out_digit = 1'b1;
                        n_started     = 1'b1;
                        if (i_sts.idx_zero) begin
                            n_state = ST_TERM;
                        end
                    end
                end
            end
            ST_TERM: begin
                if (i_sts.out_free) begin
                    cmd.out_term = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_cmd   = cmd;

endmodule

/* rtl/core/u2da_dp.sv */
// datapath: binary shift register, bcd digit register, emit counter, output register
module u2da_dp #(
    parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    input  u2da_pkg::t_cmd                i_cmd,
    output u2da_pkg::t_sts                o_sts,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [u2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import u2da_pkg::*;

    localparam int SC_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]                 r_work;
    logic [SC_W-1:0]                       r_steps;
    logic [DIGIT_SLOTS-1:0][DIGIT_W-1:0]   r_digits;
    logic [DIGIT_SLOTS-1:0][DIGIT_W-1:0]   adj;
    logic [DIGIT_SLOTS-1:0][DIGIT_W-1:0]   dbl;
    logic [IDX_W-1:0]                      r_idx;
    logic                                  r_valid;
    logic [CHAR_W-1:0]                     r_char;
    logic                                  r_last;
    logic [DIGIT_W-1:0]                    top;
    logic [DIGIT_W-1:0]                    top_clamp;

    // add 3 to every digit of five or more, then shift left by one bit
    always_comb begin
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            adj[k] = (r_digits[k] >= 4'd5) ? r_digits[k] + 4'd3 : r_digits[k];
        end
        dbl[0] = {adj[0][DIGIT_W-2:0], r_work[VALUE_BITS-1]};
        for (int k = 1; k < DIGIT_SLOTS; k++) begin
            dbl[k] = {adj[k][DIGIT_W-2:0], adj[k-1][DIGIT_W-1]};
        end
    end

    assign top       = r_digits[DIGIT_SLOTS-1];
    assign top_clamp = (top > DIGIT_MAX) ? DIGIT_MAX : top;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work   <= i_value[VALUE_BITS-1:0];
            r_steps  <= '0;
            r_digits <= '0;
            r_idx    <= IDX_W'(DIGIT_SLOTS - 1);
        end else if (i_cmd.step) begin
            r_work   <= {r_work[VALUE_BITS-2:0], 1'b0};
            r_steps  <= r_steps + 1'b1;
            r_digits <= dbl;
        end else if (i_cmd.shift) begin
            r_digits <= {r_digits[DIGIT_SLOTS-2:0], {DIGIT_W{1'b0}}};
            r_idx    <= r_idx - 1'b1;
        end
        if (i_cmd.out_digit) begin
            r_char <= CH_ZERO + CHAR_W'(top_clamp);
            r_last <= 1'b0;
        end else if (i_cmd.out_term) begin
            r_char <= CH_NUL;
            r_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_digit || i_cmd.out_term) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_sts.conv_done = (r_steps == SC_W'(VALUE_BITS - 1));
    assign o_sts.top_zero  = (top == '0);
    assign o_sts.idx_zero  = (r_idx == '0);
    assign o_sts.out_free  = !r_valid || !i_stall;

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

/* rtl/core/unsigned_to_decimal_ascii_top.sv */
// top level of the unsigned binary to decimal ascii converter
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_value
//   output   out        o_valid / i_stall  o_char_code, o_last
// one transaction in goes through a load, one shift-add-3 step per bit of VALUE_BITS, a pass
// over the digit positions from the top (20 positions, leading zeros skipped) and a terminator
// the work is done by the single shared bcd step unit and the serial digit emitter
// o_stall stays high after the load until the terminator enters the output register
// the output register holds while i_stall is high and emission pauses behind it
// reset (i_rst_n low, synchronous) clears the state machine and output valid
module unsigned_to_decimal_ascii_top #(
    parameter int VALUE_BITS = u2da_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import u2da_pkg::*;

    t_cmd cmd;
    t_sts sts;

    u2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    u2da_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule
